// ===== hdl/drpi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package drpi_pkg;

	localparam int PI_Q13 = 25736;
	localparam int TWO_PI_Q13 = 51472;
	localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [34:0] GAIN_Q30 = 35'sd652032874;
	localparam int ATAN_ENTRIES = 24;

	// configuration register indexes
	localparam logic [1:0] REG_LINEAR = 2'd0;
	localparam logic [1:0] REG_ANGULAR = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	// atan(2^-i) in Q.30
	function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
		logic signed [34:0] r;
		case (i)
			5'd0: r = 35'sd843314857;
			5'd1: r = 35'sd497837829;
			5'd2: r = 35'sd263043837;
			5'd3: r = 35'sd133525159;
			5'd4: r = 35'sd67021687;
			5'd5: r = 35'sd33543516;
			5'd6: r = 35'sd16775851;
			5'd7: r = 35'sd8388437;
			5'd8: r = 35'sd4194283;
			5'd9: r = 35'sd2097149;
			5'd10: r = 35'sd1048576;
			5'd11: r = 35'sd524288;
			5'd12: r = 35'sd262144;
			5'd13: r = 35'sd131072;
			5'd14: r = 35'sd65536;
			5'd15: r = 35'sd32768;
			5'd16: r = 35'sd16384;
			5'd17: r = 35'sd8192;
			5'd18: r = 35'sd4096;
			5'd19: r = 35'sd2048;
			5'd20: r = 35'sd1024;
			5'd21: r = 35'sd512;
			5'd22: r = 35'sd256;
			5'd23: r = 35'sd128;
			default: r = 35'sd0;
		endcase
		return r;
	endfunction

	// controller to datapath commands
	typedef struct packed {
		logic load_motion;  // seed CORDIC with old heading (Q.30 = yaw*2^17)
		logic load_quat;    // seed CORDIC with half heading (yaw*2^16)
		logic cordic_step;  // one micro-rotation
		logic mul_a;        // speed * cos, speed * sin
		logic mul_b;        // products * period
		logic commit;       // update x, y, heading
		logic result;       // register quaternion into output
	} drpi_cmd_t;

	typedef struct packed {
		logic cordic_done;
	} drpi_sts_t;

endpackage
`default_nettype wire

// ===== hdl/dead_reckoning_pose_integrator.sv =====
// Dead-reckoning pose integrator.
// Input stream: one tick request per item; s_tdata[0] = advance. Advance 1
// moves x/y by speed*cos/sin(old heading)*period and turns the heading; 0
// only reports the current pose.
// Output stream: one result per request; m_tdata packs pos_x, pos_y, heading,
// quat_z, quat_w, speed_echo, turn_echo from bit 0 up (144 bits).
// Configuration: cfg_valid/cfg_ready, cfg_ready is always high; cfg_index 0 linear speed,
// 1 angular speed, 2 tick period; the user must write them only while idle (not enforced).
// Sequence: an advancing request rotates the CORDIC by the old heading,
// multiplies speed by cos/sin and then by the period, commits the pose, rotates
// by half the new heading and registers the quaternion; a reporting request does
// only the last two, with the current heading. One shared CORDIC unit iterating
// one micro-rotation per cycle serves both rotations; one request in flight at a
// time. The next request is taken only once the result has been taken.
// Reset clears pose to zero and the registers to their defaults.
// Stall: a result waits in the output register; no new request is taken
// until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module dead_reckoning_pose_integrator #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [7:0]   s_tdata,     // [0] advance
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [143:0] m_tdata,     // pos_x, pos_y, heading, quat_z, quat_w, speed_echo, turn_echo
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [1:0]   cfg_index,
	input  wire  [15:0]  cfg_data
);
	import drpi_pkg::*;

	logic signed [15:0] lin_q, ang_q;
	logic [15:0] per_q;
	drpi_cmd_t cmd;
	drpi_sts_t sts;
	logic signed [31:0] pos_x, pos_y;
	logic signed [15:0] heading, quat_z, quat_w;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q <= 16'sd51;
			ang_q <= 16'sd410;
			per_q <= 16'd6554;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LINEAR: lin_q <= cfg_data;
				REG_ANGULAR: ang_q <= cfg_data;
				REG_PERIOD: per_q <= cfg_data;
				default: ;
			endcase
		end
	end

	drpi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .advance(s_tdata[0]),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.cmd(cmd), .sts(sts)
	);

	drpi_datapath #(.CordicSteps(CORDIC_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.linear_speed(lin_q), .angular_speed(ang_q), .tick_period(per_q),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading),
		.quat_z(quat_z), .quat_w(quat_w)
	);

	assign m_tdata = {ang_q, lin_q, quat_w, quat_z, heading, pos_y, pos_x};
endmodule
`default_nettype wire

// ===== hdl/drpi_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drpi_datapath #(
	parameter int CordicSteps = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  drpi_pkg::drpi_cmd_t     cmd,
	output drpi_pkg::drpi_sts_t     sts,
	input  wire signed [15:0]       linear_speed,
	input  wire signed [15:0]       angular_speed,
	input  wire [15:0]              tick_period,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [15:0]      heading,
	output logic signed [15:0]      quat_z,
	output logic signed [15:0]      quat_w
);
	import drpi_pkg::*;

	localparam int Steps = (CordicSteps < ATAN_ENTRIES) ? CordicSteps : ATAN_ENTRIES;
	localparam logic [4:0] LastStep = 5'(Steps - 1);

	logic signed [34:0] cx_q, cy_q, cz_q;
	logic flip_q;
	logic [4:0] step_q;
	logic signed [31:0] x_q, y_q;
	logic signed [15:0] yaw_q;
	logic signed [34:0] seed;
	logic signed [34:0] cos_v, sin_v;
	logic signed [50:0] pc_q, ps_q;      // speed * cos/sin, Q.38
	logic signed [67:0] mc_q, ms_q;      // times period, Q.54
	logic signed [67:0] rc, rs;
	logic signed [33:0] nx, ny;
	logic signed [17:0] dh, h1;
	logic signed [31:0] hw;
	logic signed [34:0] qz_r, qw_r;

	// angle seed: full heading for motion, half heading for the quaternion
	always_comb begin
		if (cmd.load_quat) seed = 35'(yaw_q) <<< 16;
		else seed = 35'(yaw_q) <<< 17;
	end

	// CORDIC rotation, one step a cycle while cordic_step is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load_motion || cmd.load_quat) begin
			step_q <= '0;
		end else if (cmd.cordic_step && step_q != LastStep) begin
			step_q <= step_q + 5'd1;
		end
	end
	assign sts.cordic_done = (step_q == LastStep);

	always_ff @(posedge clk) begin
		if (cmd.load_motion || cmd.load_quat) begin
			cx_q <= GAIN_Q30;
			cy_q <= '0;
			if (seed > HALF_PI_Q30) begin
				cz_q <= seed - PI_Q30; flip_q <= 1'b1;
			end else if (seed < -HALF_PI_Q30) begin
				cz_q <= seed + PI_Q30; flip_q <= 1'b1;
			end else begin
				cz_q <= seed; flip_q <= 1'b0;
			end
		end else if (cmd.cordic_step) begin
			if (!cz_q[34]) begin
				cx_q <= cx_q - (cy_q >>> step_q);
				cy_q <= cy_q + (cx_q >>> step_q);
				cz_q <= cz_q - atan_q30(step_q);
			end else begin
				cx_q <= cx_q + (cy_q >>> step_q);
				cy_q <= cy_q - (cx_q >>> step_q);
				cz_q <= cz_q + atan_q30(step_q);
			end
		end
	end
	assign cos_v = flip_q ? -cx_q : cx_q;
	assign sin_v = flip_q ? -cy_q : cy_q;

	// two registered multiplies
	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			pc_q <= 51'(linear_speed) * 51'(cos_v);
			ps_q <= 51'(linear_speed) * 51'(sin_v);
		end
		if (cmd.mul_b) begin
			mc_q <= 68'(pc_q) * $signed({52'd0, tick_period});
			ms_q <= 68'(ps_q) * $signed({52'd0, tick_period});
		end
	end

	// rounding, saturation, heading wrap
	always_comb begin
		rc = (mc_q + (68'sd1 <<< 37)) >>> 38;
		rs = (ms_q + (68'sd1 <<< 37)) >>> 38;
		nx = 34'(x_q) + 34'(rc);
		ny = 34'(y_q) + 34'(rs);
		hw = 32'(angular_speed) * $signed({16'd0, tick_period});
		dh = 18'((hw + 32'sd16384) >>> 15);
		h1 = 18'(yaw_q) + dh;
		if (h1 > 18'(PI_Q13)) h1 = h1 - 18'(TWO_PI_Q13);
		if (h1 < -18'(PI_Q13)) h1 = h1 + 18'(TWO_PI_Q13);
		if (h1 > 18'(PI_Q13)) h1 = 18'(PI_Q13);
		if (h1 < -18'(PI_Q13)) h1 = -18'(PI_Q13);
		qz_r = (sin_v + 35'sd32768) >>> 16;
		qw_r = (cos_v + 35'sd32768) >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			yaw_q <= '0;
		end else if (cmd.commit) begin
			x_q <= (nx > 34'sd2147483647) ? 32'sh7fffffff :
				(nx < -34'sd2147483648) ? 32'sh80000000 : 32'(nx);
			y_q <= (ny > 34'sd2147483647) ? 32'sh7fffffff :
				(ny < -34'sd2147483648) ? 32'sh80000000 : 32'(ny);
			yaw_q <= 16'(h1);
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.result) begin
			pos_x <= x_q;
			pos_y <= y_q;
			heading <= yaw_q;
			quat_z <= (qz_r > 35'sd16384) ? 16'sd16384 :
				(qz_r < -35'sd16384) ? -16'sd16384 : 16'(qz_r);
			quat_w <= (qw_r > 35'sd16384) ? 16'sd16384 :
				(qw_r < -35'sd16384) ? -16'sd16384 : 16'(qw_r);
		end
	end

`ifndef NO_ASSERTIONS
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		yaw_q <= 16'sd25736 && yaw_q >= -16'sd25736) else $error("yaw out of range");
	a_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.cordic_step && !cmd.load_quat && !cmd.load_motion |=> $stable(step_q))
		else $error("step counter moved");
	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_a |-> sts.cordic_done) else $error("multiply before CORDIC done");
`endif
endmodule
`default_nettype wire

// ===== hdl/drpi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drpi_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire                 advance,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output drpi_pkg::drpi_cmd_t cmd,
	input  drpi_pkg::drpi_sts_t sts
);
	import drpi_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_MROT  = 8'b00000010,
		ST_MULA  = 8'b00000100,
		ST_MULB  = 8'b00001000,
		ST_COMM  = 8'b00010000,
		ST_QLOAD = 8'b00100000,
		ST_QROT  = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;

	// one item at a time; the output register holds until taken
	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					if (advance) begin
						cmd.load_motion = 1'b1;
						state_d = ST_MROT;
					end else begin
						state_d = ST_QLOAD;
					end
				end
			end
			ST_MROT: begin
				cmd.cordic_step = 1'b1;
				if (sts.cordic_done) state_d = ST_MULA;
			end
			ST_MULA: begin
				cmd.mul_a = 1'b1;
				state_d = ST_MULB;
			end
			ST_MULB: begin
				cmd.mul_b = 1'b1;
				state_d = ST_COMM;
			end
			ST_COMM: begin
				cmd.commit = 1'b1;
				state_d = ST_QLOAD;
			end
			ST_QLOAD: begin
				cmd.load_quat = 1'b1;
				state_d = ST_QROT;
			end
			ST_QROT: begin
				cmd.cordic_step = 1'b1;
				if (sts.cordic_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.result = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> !out_valid_q) else $error("result overwritten");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != ST_IDLE) else $error("accept lost");
`endif
endmodule
`default_nettype wire
